// File: hw/rtl/tdpc_pkg.sv
`timescale 1ns / 1ps

package tdpc_pkg;

   localparam int MAX_SIDE_DEF = 64;
   localparam int SIDE_W       = 7;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
   localparam logic [SIDE_W-1:0] SIDE_ONE   = 7'd1;

   // register index taken from paddr[2]
   localparam logic CSR_IDX_SIDE = 1'b0;

   // odd row count saturates here
   localparam logic [1:0] ODD_NONE = 2'd0;
   localparam logic [1:0] ODD_ONE  = 2'd1;
   localparam logic [1:0] ODD_MANY = 2'd2;

   typedef enum logic [1:0] {
      VERDICT_OK      = 2'd0,
      VERDICT_FIX     = 2'd1,
      VERDICT_CORRUPT = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [1:0]        odd_rows;
      logic [SIDE_W-1:0] odd_row_idx;
   } row_sum_type;

endpackage

// File: hw/rtl/tdpc_req_if.sv
`timescale 1ns / 1ps

interface tdpc_req_if;
   logic valid;
   logic ready;
   logic bit_value;

   modport source (output valid, output bit_value, input ready);
   modport sink (input valid, input bit_value, output ready);
endinterface

// File: hw/rtl/tdpc_rsp_if.sv
`timescale 1ns / 1ps

interface tdpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     verdict;
   logic [tdpc_pkg::SIDE_W-1:0]    error_row;
   logic [tdpc_pkg::SIDE_W-1:0]    error_col;

   modport source (output valid, output verdict, output error_row, output error_col,
                   input ready);
   modport sink (input valid, input verdict, input error_row, input error_col,
                 output ready);
endinterface

// File: hw/rtl/two_dim_parity_check_locate_unit.sv
// two-dimensional parity check with single-error location, one bit per request
// throughput: one request per cycle while the queue has room, and side-1 matrices
// give a response per cycle while the receiver is ready; a finished matrix summary
// passes a two-entry queue, parting the parity front from the registered verdict stage
// reset (synchronous, active high) clears all parity state, queue and output; side = 64
`timescale 1ns / 1ps

module two_dim_parity_check_locate_unit #(
   parameter int MAX_SIDE = tdpc_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tdpc_req_if.sink                      req_chan,
   tdpc_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tdpc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tdpc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tdpc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int QW = MAX_SIDE + $bits(tdpc_pkg::row_sum_type);

   logic [tdpc_pkg::SIDE_W-1:0]   side_ff, side_in;
   logic [tdpc_pkg::SIDE_W-1:0]   side_eff;
   logic                          side_wr;

   logic                          push, pop, q_empty, q_full;
   logic [MAX_SIDE-1:0]           front_col_par;
   tdpc_pkg::row_sum_type         front_row_sum;
   logic [QW-1:0]                 head;
   logic [MAX_SIDE-1:0]           back_col_par;
   tdpc_pkg::row_sum_type         back_row_sum;

   // configuration port
   assign csr_pready = 1'b1;
   assign side_wr    = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == tdpc_pkg::CSR_IDX_SIDE);
   assign side_in    = side_wr ? csr_pwdata[tdpc_pkg::SIDE_W-1:0] : side_ff;
   assign csr_prdata = (csr_paddr[2] == tdpc_pkg::CSR_IDX_SIDE) ?
                       tdpc_pkg::CSR_DW'(side_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= tdpc_pkg::SIDE_RESET;
      end else begin
         side_ff <= side_in;
      end
   end

   // zero acts as one, anything past the limit as the limit
   always_comb begin
      if (side_ff == '0) begin
         side_eff = tdpc_pkg::SIDE_ONE;
      end else if (int'(side_ff) > MAX_SIDE) begin
         side_eff = tdpc_pkg::SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
   end

   tdpc_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (side_wr),
      .side_eff   (side_eff),
      .req_chan   (req_chan),
      .queue_full (q_full),
      .push       (push),
      .col_par    (front_col_par),
      .row_sum    (front_row_sum)
   );

   tdpc_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_col_par, front_row_sum}),
      .pop       (pop),
      .head_data (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign back_col_par = head[QW-1 -: MAX_SIDE];
   assign back_row_sum = head[$bits(tdpc_pkg::row_sum_type)-1:0];

   tdpc_back #(.MAX_SIDE(MAX_SIDE)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .col_par     (back_col_par),
      .row_sum     (back_row_sum),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // locations only accompany a single-bit fix
   a_loc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.verdict != tdpc_pkg::VERDICT_FIX) |->
      (rsp_chan.error_row == '0 && rsp_chan.error_col == '0))
      else $error("location given without a fix verdict");

   a_loc_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.verdict == tdpc_pkg::VERDICT_FIX) |->
      (rsp_chan.error_row != '0 && rsp_chan.error_col != '0 &&
       rsp_chan.error_row <= side_eff && rsp_chan.error_col <= side_eff))
      else $error("fix location outside the matrix");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !q_empty)
      else $error("finished matrix summary lost");

endmodule

// File: hw/rtl/tdpc_queue.sv
`timescale 1ns / 1ps

module tdpc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] mem [tdpc_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'(tdpc_pkg::QUEUE_DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/tdpc_front.sv
`timescale 1ns / 1ps

module tdpc_front #(
   parameter int MAX_SIDE = tdpc_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [tdpc_pkg::SIDE_W-1:0]   side_eff,
   tdpc_req_if.sink                      req_chan,
   input  logic                          queue_full,
   output logic                          push,
   output logic [MAX_SIDE-1:0]           col_par,
   output tdpc_pkg::row_sum_type         row_sum
);

   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CMP_W = (IDX_W > tdpc_pkg::SIDE_W) ? IDX_W : tdpc_pkg::SIDE_W;

   logic [IDX_W-1:0]              col_ff, col_in;
   logic [IDX_W-1:0]              row_ff, row_in;
   logic                          row_par_ff, row_par_in;
   logic [MAX_SIDE-1:0]           col_par_ff, col_par_in;
   logic [1:0]                    odd_cnt_ff, odd_cnt_in;
   logic [tdpc_pkg::SIDE_W-1:0]   odd_idx_ff, odd_idx_in;

   logic                          accept;
   logic                          last_col, last_row;
   logic                          row_par_next;
   logic [MAX_SIDE-1:0]           col_par_next;
   logic [1:0]                    odd_cnt_next;
   logic [tdpc_pkg::SIDE_W-1:0]   odd_idx_next;
   logic [tdpc_pkg::SIDE_W-1:0]   side_m1;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   assign side_m1  = side_eff - tdpc_pkg::SIDE_ONE;
   assign last_col = (CMP_W'(col_ff) == CMP_W'(side_m1));
   assign last_row = (CMP_W'(row_ff) == CMP_W'(side_m1));

   assign row_par_next = row_par_ff ^ req_chan.bit_value;

   always_comb begin
      for (int i = 0; i < MAX_SIDE; i++) begin
         col_par_next[i] = col_par_ff[i] ^
                           (req_chan.bit_value && (col_ff == IDX_W'(i)));
      end
   end

   // row summary as it stands once this bit closes its row
   always_comb begin
      odd_cnt_next = odd_cnt_ff;
      odd_idx_next = odd_idx_ff;
      if (row_par_next) begin
         if (odd_cnt_ff != tdpc_pkg::ODD_MANY) begin
            odd_cnt_next = odd_cnt_ff + 2'd1;
         end
         odd_idx_next = tdpc_pkg::SIDE_W'(row_ff) + tdpc_pkg::SIDE_ONE;
      end
   end

   assign push                 = accept && last_col && last_row;
   assign col_par              = col_par_next;
   assign row_sum.odd_rows     = odd_cnt_next;
   assign row_sum.odd_row_idx  = odd_idx_next;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      row_par_in = row_par_ff;
      col_par_in = col_par_ff;
      odd_cnt_in = odd_cnt_ff;
      odd_idx_in = odd_idx_ff;
      if (clear) begin
         col_in     = '0;
         row_in     = '0;
         row_par_in = 1'b0;
         col_par_in = '0;
         odd_cnt_in = tdpc_pkg::ODD_NONE;
         odd_idx_in = '0;
      end else if (accept) begin
         if (!last_col) begin
            col_in     = col_ff + IDX_W'(1);
            row_par_in = row_par_next;
            col_par_in = col_par_next;
         end else if (!last_row) begin
            col_in     = '0;
            row_in     = row_ff + IDX_W'(1);
            row_par_in = 1'b0;
            col_par_in = col_par_next;
            odd_cnt_in = odd_cnt_next;
            odd_idx_in = odd_idx_next;
         end else begin
            // matrix done, summary goes to the queue
            col_in     = '0;
            row_in     = '0;
            row_par_in = 1'b0;
            col_par_in = '0;
            odd_cnt_in = tdpc_pkg::ODD_NONE;
            odd_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_par_ff <= 1'b0;
         col_par_ff <= '0;
         odd_cnt_ff <= tdpc_pkg::ODD_NONE;
         odd_idx_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_par_ff <= row_par_in;
         col_par_ff <= col_par_in;
         odd_cnt_ff <= odd_cnt_in;
         odd_idx_ff <= odd_idx_in;
      end
   end

endmodule

// File: hw/rtl/tdpc_back.sv
`timescale 1ns / 1ps

module tdpc_back #(
   parameter int MAX_SIDE = tdpc_pkg::MAX_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  logic [MAX_SIDE-1:0]     col_par,
   input  tdpc_pkg::row_sum_type   row_sum,
   output logic                    pop,
   tdpc_rsp_if.source              rsp_chan
);

   logic                          valid_ff, valid_in;
   logic [1:0]                    verdict_ff, verdict_in;
   logic [tdpc_pkg::SIDE_W-1:0]   row_ff, row_in;
   logic [tdpc_pkg::SIDE_W-1:0]   col_ff, col_in;

   logic                          no_cols, one_col;
   logic [tdpc_pkg::SIDE_W-1:0]   col_idx;
   tdpc_pkg::verdict_type         verdict;

   assign no_cols = (col_par == '0);
   // single set bit: clearing the lowest one leaves nothing
   assign one_col = !no_cols && ((col_par & (col_par - MAX_SIDE'(1))) == '0);

   always_comb begin
      col_idx = '0;
      for (int j = 0; j < MAX_SIDE; j++) begin
         if (col_par[j]) begin
            col_idx = tdpc_pkg::SIDE_W'(j + 1);
         end
      end
   end

   always_comb begin
      if (row_sum.odd_rows == tdpc_pkg::ODD_NONE && no_cols) begin
         verdict = tdpc_pkg::VERDICT_OK;
      end else if (row_sum.odd_rows == tdpc_pkg::ODD_ONE && one_col) begin
         verdict = tdpc_pkg::VERDICT_FIX;
      end else begin
         verdict = tdpc_pkg::VERDICT_CORRUPT;
      end
   end

   assign pop = !queue_empty && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in   = valid_ff;
      verdict_in = verdict_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      if (pop) begin
         valid_in   = 1'b1;
         verdict_in = verdict;
         row_in     = (verdict == tdpc_pkg::VERDICT_FIX) ? row_sum.odd_row_idx : '0;
         col_in     = (verdict == tdpc_pkg::VERDICT_FIX) ? col_idx : '0;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.verdict   = verdict_ff;
   assign rsp_chan.error_row = row_ff;
   assign rsp_chan.error_col = col_ff;

endmodule

// File: sim/two_dim_parity_check_locate_checker.sv
`timescale 1ns / 1ps

module two_dim_parity_check_locate_checker
   import tdpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tdpc_req_if               req_mon,
   tdpc_rsp_if               rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic [CSR_DW-1:0] csr_prdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_count,
   output int                ok_seen,
   output int                fix_seen,
   output int                corrupt_seen
);

   typedef struct {
      verdict_type       verdict;
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] col;
   } parity_verdict_type;

   parity_verdict_type expected_verdicts[$];

   logic [MAX_SIDE_DEF-1:0] col_parity;
   logic                    row_parity;
   logic [1:0]              odd_rows;
   logic [SIDE_W-1:0]       odd_row_idx;
   logic [SIDE_W-1:0]       side_raw;
   int                      row_pos;
   int                      col_pos;

   int fails = 0;
   int n_ok = 0;
   int n_fix = 0;
   int n_corrupt = 0;

   task report(input string msg);
      $display("[%0t] error: %s", $realtime, msg);
      fails++;
   endtask

   function automatic int used_side();
      if (side_raw == '0) return 1;
      if (side_raw > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return int'(side_raw);
   endfunction

   task clear_matrix();
      col_parity  = '0;
      row_parity  = 1'b0;
      odd_rows    = ODD_NONE;
      odd_row_idx = '0;
      row_pos     = 0;
      col_pos     = 0;
   endtask

   task automatic absorb_bit(input logic b);
      int side;
      int odd_cols;
      int odd_col_idx;
      parity_verdict_type v;
      side = used_side();
      if (col_pos >= side) col_pos = 0;
      col_parity[col_pos] = col_parity[col_pos] ^ b;
      row_parity = row_parity ^ b;
      col_pos++;
      if (col_pos < side) return;
      // row complete
      col_pos = 0;
      if (row_parity) begin
         if (odd_rows != ODD_MANY) odd_rows++;
         odd_row_idx = SIDE_W'(row_pos + 1);
      end
      row_parity = 1'b0;
      row_pos++;
      if (row_pos < side) return;
      // matrix complete
      odd_cols = 0;
      odd_col_idx = 0;
      for (int j = 0; j < side; j++) begin
         if (col_parity[j]) begin
            odd_cols++;
            odd_col_idx = j + 1;
         end
      end
      v.row = '0;
      v.col = '0;
      if (odd_rows == ODD_NONE && odd_cols == 0) begin
         v.verdict = VERDICT_OK;
      end else if (odd_rows == ODD_ONE && odd_cols == 1) begin
         v.verdict = VERDICT_FIX;
         v.row = odd_row_idx;
         v.col = SIDE_W'(odd_col_idx);
      end else begin
         v.verdict = VERDICT_CORRUPT;
      end
      expected_verdicts.push_back(v);
      clear_matrix();
   endtask

   task automatic check_response();
      parity_verdict_type v;
      if (expected_verdicts.size() == 0) begin
         report($sformatf("response with none expected: verdict %0d row %0d col %0d",
                          rsp_mon.verdict, rsp_mon.error_row, rsp_mon.error_col));
         return;
      end
      v = expected_verdicts.pop_front();
      if (rsp_mon.verdict !== v.verdict)
         report($sformatf("verdict got %0d want %s", rsp_mon.verdict, v.verdict.name()));
      if (rsp_mon.error_row !== v.row)
         report($sformatf("error_row got %0d want %0d", rsp_mon.error_row, v.row));
      if (rsp_mon.error_col !== v.col)
         report($sformatf("error_col got %0d want %0d", rsp_mon.error_col, v.col));
      case (v.verdict)
         VERDICT_OK:  n_ok++;
         VERDICT_FIX: n_fix++;
         default:     n_corrupt++;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         side_raw = SIDE_RESET;
         clear_matrix();
         expected_verdicts.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_SIDE) begin
                  side_raw = csr_pwdata[SIDE_W-1:0];
                  clear_matrix();
               end
            end else if (csr_paddr[2] == CSR_IDX_SIDE &&
                         csr_prdata[SIDE_W-1:0] !== side_raw) begin
               report($sformatf("side readback got %0d want %0d",
                                csr_prdata[SIDE_W-1:0], side_raw));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready) absorb_bit(req_mon.bit_value);
      end
      pending_count <= expected_verdicts.size();
      fail_count    <= fails;
      ok_seen       <= n_ok;
      fix_seen      <= n_fix;
      corrupt_seen  <= n_corrupt;
   end

endmodule

// File: sim/two_dim_parity_check_locate_unit_tb.sv
`timescale 1ns / 1ps

module two_dim_parity_check_locate_unit_tb;
   import tdpc_pkg::*;

   localparam int LIMIT_CYCLES   = 600000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_UNTIL   = 1450;

   localparam logic [CSR_AW-1:0] SIDE_ADDR  = {CSR_IDX_SIDE, 2'b00};
   localparam logic [CSR_AW-1:0] SPARE_ADDR = {~CSR_IDX_SIDE, 2'b00};

   localparam logic [SIDE_W-1:0] SIDE_ZERO    = 7'd0;
   localparam logic [SIDE_W-1:0] SIDE_TWO     = 7'd2;
   localparam logic [SIDE_W-1:0] SIDE_CLAMPED = 7'd127;

   // side-2 matrices: clean, fix (1,1), fix (2,2), two odd columns
   localparam logic [15:0] SIDE2_PATTERN = 16'b1111_1000_0001_1100;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int pending_count;
   int ok_seen;
   int fix_seen;
   int corrupt_seen;

   int  cycle_count = 0;
   int  bits_sent = 0;
   int  csr_ops = 0;
   int  burst_left = 0;
   int  gap_mode = 0;
   bit  hold_off_toggle = 1'b0;

   tdpc_req_if req_bus();
   tdpc_rsp_if rsp_bus();

   two_dim_parity_check_locate_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   two_dim_parity_check_locate_checker parity_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .ok_seen       (ok_seen),
      .fix_seen      (fix_seen),
      .corrupt_seen  (corrupt_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int gap_pick();
      case (gap_mode)
         0:       return 0;
         1:       return $urandom_range(0, 3);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   task send_bit(input logic b);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.bit_value <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bits_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = gap_pick();
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // hold the sender until every verdict is back, then let the pipe drain
   task wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_access(input logic wr, input logic [CSR_AW-1:0] addr,
                   input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_ops++;
   endtask

   task set_side(input logic [SIDE_W-1:0] raw);
      csr_access(1'b1, SIDE_ADDR, ($urandom() & ~32'h7f) | CSR_DW'(raw));
   endtask

   task automatic send_matrix(input int side, input int flips, input bit noise,
                              input int pin_row, input int pin_col);
      logic grid [0:MAX_SIDE_DEF-1][0:MAX_SIDE_DEF-1];
      logic acc;
      int   r;
      int   c;
      for (r = 0; r < side; r++)
         for (c = 0; c < side; c++)
            grid[r][c] = noise ? 1'($urandom_range(0, 1)) : 1'b0;
      if (!noise) begin
         // random body, last row and column make every line even
         for (r = 0; r < side - 1; r++)
            for (c = 0; c < side - 1; c++)
               grid[r][c] = 1'($urandom_range(0, 1));
         for (r = 0; r < side - 1; r++) begin
            acc = 1'b0;
            for (c = 0; c < side - 1; c++) acc ^= grid[r][c];
            grid[r][side-1] = acc;
         end
         for (c = 0; c < side; c++) begin
            acc = 1'b0;
            for (r = 0; r < side - 1; r++) acc ^= grid[r][c];
            grid[side-1][c] = acc;
         end
      end
      for (int f = 0; f < flips; f++) begin
         if (f == 0 && pin_row >= 0) begin
            r = pin_row;
            c = pin_col;
         end else begin
            r = $urandom_range(0, side - 1);
            c = $urandom_range(0, side - 1);
         end
         grid[r][c] = ~grid[r][c];
      end
      for (r = 0; r < side; r++)
         for (c = 0; c < side; c++)
            send_bit(grid[r][c]);
   endtask

   task random_matrix(input int side);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      send_matrix(side, 0, 1'b0, -1, -1);
      else if (pick < 65) send_matrix(side, 1, 1'b0, -1, -1);
      else if (pick < 85) send_matrix(side, $urandom_range(2, 4), 1'b0, -1, -1);
      else                send_matrix(side, 0, 1'b1, -1, -1);
   endtask

   // receiver: segments of random length, each with its own stall pattern
   initial begin
      int  seg_len;
      int  mode;
      bit  hold_seen;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_toggle != hold_seen) begin
            hold_seen = hold_off_toggle;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         seg_len = $urandom_range(1, 60);
         for (int k = 0; k < seg_len; k++) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= k[2];
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int phase;
      int side;
      logic [SIDE_W-1:0] raw;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.bit_value <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // partial matrix at the reset side, dropped by the side write
      gap_mode = 1;
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);
      wait_idle();
      set_side(SIDE_ONE);
      csr_access(1'b0, SIDE_ADDR, '0);
      send_bit(1'b0);
      send_bit(1'b1);
      // side zero behaves as side one
      wait_idle();
      set_side(SIDE_ZERO);
      csr_access(1'b0, SIDE_ADDR, '0);
      send_bit(1'b1);
      send_bit(1'b0);
      // write to an unmapped register must leave the side alone
      wait_idle();
      csr_access(1'b1, SPARE_ADDR, 32'h2);
      csr_access(1'b0, SIDE_ADDR, '0);
      send_bit(1'b1);
      wait_idle();
      set_side(SIDE_TWO);
      for (int i = 15; i >= 0; i--) send_bit(SIDE2_PATTERN[i]);
      // unmapped write in the middle of a matrix does not drop it
      send_bit(1'b1);
      wait_idle();
      csr_access(1'b1, SPARE_ADDR, 32'h5);
      send_bit(1'b0);
      send_bit(1'b0);
      send_bit(1'b0);

      phase = 0;
      while (bits_sent < RANDOM_UNTIL) begin
         wait_idle();
         if (phase == 2) begin
            // receiver holds off while side-1 requests keep coming
            set_side(SIDE_ONE);
            gap_mode = 0;
            hold_off_toggle <= ~hold_off_toggle;
            repeat (150) send_bit(1'($urandom_range(0, 1)));
         end else begin
            case ($urandom_range(0, 9))
               0:          raw = SIDE_ZERO;
               1, 2:       raw = SIDE_ONE;
               3, 4, 5, 6: raw = SIDE_W'($urandom_range(2, 5));
               7, 8:       raw = SIDE_W'($urandom_range(6, 9));
               default:    raw = SIDE_W'($urandom_range(10, 14));
            endcase
            set_side(raw);
            if ($urandom_range(0, 4) == 0) csr_access(1'b1, SPARE_ADDR, $urandom());
            if ($urandom_range(0, 2) == 0) csr_access(1'b0, SIDE_ADDR, '0);
            side = (raw == SIDE_ZERO) ? 1 : int'(raw);
            gap_mode = $urandom_range(0, 2);
            repeat ($urandom_range(1, 6)) random_matrix(side);
            // trailing partial matrix, dropped by the next side write
            if (side > 1 && $urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, side * side - 1)) send_bit(1'($urandom_range(0, 1)));
         end
         phase++;
      end

      // two rows at the largest side, set through the clamp; no verdict is due
      wait_idle();
      set_side(SIDE_CLAMPED);
      csr_access(1'b0, SIDE_ADDR, '0);
      gap_mode = 1;
      repeat (2 * MAX_SIDE_DEF) send_bit(1'($urandom_range(0, 1)));

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d matrix bits over sides 0 to 14 plus two rows at the clamped side, %0d csr accesses",
               bits_sent, csr_ops);
      $display("verdicts checked: %0d ok, %0d single-bit fix, %0d corrupt",
               ok_seen, fix_seen, corrupt_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tdpc_pkg.sv
hw/rtl/tdpc_req_if.sv
hw/rtl/tdpc_rsp_if.sv
hw/rtl/tdpc_queue.sv
hw/rtl/tdpc_front.sv
hw/rtl/tdpc_back.sv
hw/rtl/two_dim_parity_check_locate_unit.sv
sim/two_dim_parity_check_locate_checker.sv
sim/two_dim_parity_check_locate_unit_tb.sv
